// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables for the odometry and point transform block
package ddo_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int MaxBeamsDefault    = 4096;

    localparam logic [15:0] WheelRadiusReset = 16'd2163;
    localparam logic [23:0] InverseAxleReset = 24'd409600;
    localparam logic [12:0] BeamCountReset   = 13'd360;

    localparam logic [31:0] InvTwoPiQ32  = 32'd683565276;
    localparam logic [31:0] CordicGain   = 32'd652032874;
    localparam logic [31:0] QuarterTurn  = 32'h4000_0000;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_STEP  = 2'd1,
        OP_POINT = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_WHEEL_RADIUS = 2'd0,
        REG_INVERSE_AXLE = 2'd1,
        REG_BEAM_COUNT   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic        kind;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [19:0] local_x;
        logic [19:0] local_y;
        logic [15:0] beam_angle;
    } t_result;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] left_wheel_angle;
        logic [31:0] right_wheel_angle;
        logic [19:0] point_x;
        logic [19:0] point_y;
        logic        point_valid;
        logic [11:0] beam_index;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture item, do init work
        logic prep;     // wheel deltas ready, form travel products
        logic heading;  // update heading, start cordic
        logic iter;     // one cordic step
        logic mul;      // form rotation products
        logic apply;    // update pose or world point
        logic div_step; // one quotient bit of the beam angle
    } t_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic       cordic_done;
        logic       div_done;
    } t_status;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ddo_stream_if.sv =====
// valid/ready channel carrying one payload word
interface ddo_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ddo_ctrl.sv =====
// sequencer that steps the datapath through one item
module ddo_ctrl import ddo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_ITER  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_APPLY = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;

    // new word may enter while a result waits; the next result holds in apply until the waiting one is taken
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                priority if (i_status.opcode == OP_STEP) begin
                    o_cmd.prep = 1'b1;
                    n_state = S_HEAD;
                end else if (i_status.opcode == OP_POINT) begin
                    n_state = S_HEAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HEAD: begin
                o_cmd.heading = 1'b1;
                n_state = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter     = 1'b1;
                o_cmd.div_step = 1'b1;
                if (i_status.cordic_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul      = 1'b1;
                o_cmd.div_step = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.apply = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ddo_datapath.sv =====
// pose state, shared cordic, multipliers and beam angle divider
module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDefault,
    parameter int MAX_BEAMS    = MaxBeamsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic [15:0] i_wheel_radius,
    input  logic [23:0] i_inverse_axle,
    input  logic [12:0] i_beam_count,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_result     o_result
);

    localparam int StepW  = $clog2(CORDIC_STEPS + 1);
    localparam int BeamW  = $clog2(MAX_BEAMS + 1);
    localparam int NumW   = 28;
    localparam int DivCnt = NumW;

    // pose state
    logic [31:0] r_last_left, r_last_right;
    logic [31:0] r_robot_x, r_robot_y, r_heading;
    logic [19:0] r_held_x, r_held_y;
    logic [1:0]  r_op;
    logic [11:0] r_beam_index;

    // step arithmetic
    logic signed [31:0] r_dla, r_dra;
    logic signed [33:0] r_dc;
    logic signed [33:0] r_ddiff;
    logic        [31:0] r_k;

    // cordic
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_neg;
    logic [StepW-1:0]   r_iter;

    // products
    logic signed [67:0] r_p0, r_p1, r_p2, r_p3;

    // divider
    logic [NumW-1:0]    r_rem_num;
    logic [BeamW:0]     r_rem;
    logic [15:0]        r_quot;
    logic [5:0]         r_div_cnt;

    t_result r_result;

    // combinational helpers
    logic signed [47:0] dl_full, dr_full;
    logic signed [31:0] dl, dr;
    logic signed [33:0] sum_lr;
    logic [55:0]        k_full;
    logic signed [65:0] dth_full;
    logic [31:0]        new_heading, head_src;
    logic signed [33:0] z0;
    logic               neg0;
    logic signed [33:0] sx_cx, sx_cy;
    logic [4:0]         iter_idx;
    logic signed [33:0] cos_v, sin_v;
    logic signed [19:0] lx, ly;
    logic signed [67:0] world_x, world_y;
    logic [BeamW-1:0]   cnt;
    logic [BeamW:0]     rem_shift;

    assign dl_full  = $signed(r_dla) * $signed({1'b0, i_wheel_radius});
    assign dr_full  = $signed(r_dra) * $signed({1'b0, i_wheel_radius});
    assign dl       = dl_full[47:16];
    assign dr       = dr_full[47:16];
    assign sum_lr   = 34'(dl) + 34'(dr);
    assign k_full   = i_inverse_axle * InvTwoPiQ32;
    assign dth_full = r_ddiff * $signed({1'b0, r_k});
    assign new_heading = (r_op == OP_STEP) ? r_heading + dth_full[39:8] : r_heading;
    assign head_src = new_heading;

    // fold into half turn around zero
    always_comb begin
        z0   = 34'(signed'(head_src));
        neg0 = 1'b0;
        if (z0 > $signed({2'b00, QuarterTurn})) begin
            z0   = z0 - 34'sh0_8000_0000;
            neg0 = 1'b1;
        end else if (z0 < -$signed({2'b00, QuarterTurn})) begin
            z0   = z0 + 34'sh0_8000_0000;
            neg0 = 1'b1;
        end
    end

    assign iter_idx = 5'(r_iter);
    assign sx_cx = r_cx >>> iter_idx;
    assign sx_cy = r_cy >>> iter_idx;
    assign cos_v = r_neg ? -r_cx : r_cx;
    assign sin_v = r_neg ? -r_cy : r_cy;
    assign lx = signed'(r_held_x);
    assign ly = signed'(r_held_y);
    assign world_x = r_p0 - r_p1;
    assign world_y = r_p2 + r_p3;

    always_comb begin
        if (i_beam_count == 13'd0) begin
            cnt = BeamW'(1);
        end else if (32'(i_beam_count) > 32'(MAX_BEAMS)) begin
            cnt = BeamW'(MAX_BEAMS);
        end else begin
            cnt = BeamW'(i_beam_count);
        end
    end
    assign rem_shift = {r_rem[BeamW-1:0], r_rem_num[NumW-1]};

    assign o_status.opcode      = r_op;
    assign o_status.cordic_done = (32'(r_iter) >= 32'(CORDIC_STEPS - 1));
    assign o_status.div_done    = (r_div_cnt == 6'd0);
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_left  <= '0;
            r_last_right <= '0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_heading    <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_op         <= OP_NONE;
        end else begin
            if (i_cmd.load) begin
                r_op         <= i_item.opcode;
                r_beam_index <= i_item.beam_index;
                r_dla <= i_item.left_wheel_angle - r_last_left;
                r_dra <= i_item.right_wheel_angle - r_last_right;
                if (i_item.opcode == OP_INIT || i_item.opcode == OP_STEP) begin
                    r_last_left  <= i_item.left_wheel_angle;
                    r_last_right <= i_item.right_wheel_angle;
                end
                if (i_item.opcode == OP_INIT) begin
                    r_robot_x <= '0;
                    r_robot_y <= '0;
                    r_heading <= '0;
                end
                if (i_item.opcode == OP_POINT && i_item.point_valid) begin
                    r_held_x <= i_item.point_x;
                    r_held_y <= i_item.point_y;
                end
                r_ddiff <= '0;
            end
            if (i_cmd.prep) begin
                r_dc    <= sum_lr >>> 1;
                r_ddiff <= 34'(dr) - 34'(dl);
                r_k     <= k_full[55:24];
            end
            if (i_cmd.heading) begin
                r_heading <= new_heading;
                r_cx      <= 34'(signed'(CordicGain));
                r_cy      <= '0;
                r_cz      <= z0;
                r_neg     <= neg0;
                r_iter    <= '0;
                r_rem_num <= NumW'({r_beam_index, 16'd0});
                r_rem     <= '0;
                r_quot    <= '0;
                r_div_cnt <= 6'(DivCnt);
            end
            if (i_cmd.iter && !o_status.cordic_done) begin
                r_iter <= r_iter + 1'b1;
            end
            if (i_cmd.iter) begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - sx_cy;
                    r_cy <= r_cy + sx_cx;
                    r_cz <= r_cz - $signed({2'b00, atan_turn(iter_idx)});
                end else begin
                    r_cx <= r_cx + sx_cy;
                    r_cy <= r_cy - sx_cx;
                    r_cz <= r_cz + $signed({2'b00, atan_turn(iter_idx)});
                end
            end
            if (i_cmd.div_step && r_div_cnt != 6'd0) begin
                r_rem_num <= {r_rem_num[NumW-2:0], 1'b0};
                r_div_cnt <= r_div_cnt - 1'b1;
                if (rem_shift >= {1'b0, cnt}) begin
                    r_rem  <= rem_shift - {1'b0, cnt};
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem  <= rem_shift;
                    r_quot <= {r_quot[14:0], 1'b0};
                end
            end
            if (i_cmd.mul) begin
                if (r_op == OP_STEP) begin
                    r_p0 <= r_dc * cos_v;
                    r_p2 <= r_dc * sin_v;
                    r_p1 <= '0;
                    r_p3 <= '0;
                end else begin
                    r_p0 <= 68'(lx) * cos_v;
                    r_p1 <= 68'(ly) * sin_v;
                    r_p2 <= 68'(ly) * cos_v;
                    r_p3 <= 68'(lx) * sin_v;
                end
            end
            if (i_cmd.apply) begin
                if (r_op == OP_STEP) begin
                    r_robot_x <= r_robot_x + world_x[61:30];
                    r_robot_y <= r_robot_y + world_y[61:30];
                    r_result.kind       <= 1'b0;
                    r_result.pos_x      <= r_robot_x + world_x[61:30];
                    r_result.pos_y      <= r_robot_y + world_y[61:30];
                    r_result.local_x    <= '0;
                    r_result.local_y    <= '0;
                    r_result.beam_angle <= '0;
                end else begin
                    r_result.kind       <= 1'b1;
                    r_result.pos_x      <= r_robot_x + world_x[61:30];
                    r_result.pos_y      <= r_robot_y + world_y[61:30];
                    r_result.local_x    <= r_held_x;
                    r_result.local_y    <= r_held_y;
                    r_result.beam_angle <= r_quot;
                end
                r_result.heading <= r_heading;
            end
        end
    end

endmodule

// ===== rtl/diff_drive_odometry_point_transform.sv =====
// top level of the differential drive odometry and lidar point transform
//
// usage: items arrive on the in channel (valid/ready, accepted when both high).
// opcode 0 latches both wheel angles and clears the pose, giving no result.
// opcode 1 integrates the pose from wheel angle deltas and reports it.
// opcode 2 maps a lidar point (or the last valid one) into the world frame
// and reports it with its beam angle. opcode 3 is dropped without effect.
// results leave on the out channel, one word per step or point item.
// sequencing: init and opcode 3 free the input after the prep state; step
// and point items pass through the prep, heading, cordic, multiply, divide,
// apply and output states before out valid rises, and the bit-serial beam
// angle divider runs beside the serial cordic and is waited for in divide.
// one item is in flight at a time, so the next word is accepted only once
// the result is in the output register, which holds it while the receiver
// stalls; a further result waits until the previous one is
// taken, and the input stalls meanwhile.
// configuration writes (index 0 wheel radius, 1 inverse axle, 2 beam count)
// must only occur while idle. synchronous reset clears pose, held point,
// last wheel angles and restores register defaults.
module diff_drive_odometry_point_transform import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDefault,
    parameter int MAX_BEAMS    = MaxBeamsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddo_stream_if.sink   in_if,
    ddo_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [15:0] r_wheel_radius;
    logic [23:0] r_inverse_axle;
    logic [12:0] r_beam_count;
    t_cmd        cmd;
    t_status     status;
    t_item       item;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius <= WheelRadiusReset;
            r_inverse_axle <= InverseAxleReset;
            r_beam_count   <= BeamCountReset;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_WHEEL_RADIUS: r_wheel_radius <= i_cfg_data[15:0];
                REG_INVERSE_AXLE: r_inverse_axle <= i_cfg_data;
                REG_BEAM_COUNT:   r_beam_count   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign item        = in_if.data;
    assign out_if.data = result;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .o_in_ready  (in_if.ready),
        .o_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .MAX_BEAMS    (MAX_BEAMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_wheel_radius (r_wheel_radius),
        .i_inverse_axle (r_inverse_axle),
        .i_beam_count   (r_beam_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result       (result)
    );

endmodule
